FILE: hdl/internet_checksum_stream_defines.svh
// Assertion macros used by the checker file of the checksum block.
`ifndef INTERNET_CHECKSUM_STREAM_DEFINES_SVH
`define INTERNET_CHECKSUM_STREAM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("checksum block assertion failed");

// Consequent starts in the cycle after the antecedent.
`define ICS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("checksum block assertion failed");

`endif

FILE: hdl/ics_pkg.sv
package ics_pkg;

  localparam int unsigned SumW   = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;

  localparam logic [1:0] PROTO_IP  = 2'd0;
  localparam logic [1:0] PROTO_UDP = 2'd1;
  localparam logic [1:0] PROTO_TCP = 2'd2;
  localparam logic [1:0] PROTO_RAW = 2'd3;

  localparam logic [SumW-1:0] PROTO_UDP_ADD = 32'd17;
  localparam logic [SumW-1:0] PROTO_TCP_ADD = 32'd6;
  localparam logic [SumW-1:0] ADDR_PAIR_LEN = 32'd8;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
    logic [1:0]       proto_mode;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0]  checksum_value;
    logic [CountW-1:0] bytes_summed;
  } out_item_t;

  // Totals of a finished message, handed from the accumulator to the pipeline.
  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [SumW-1:0]   term;
    logic [CountW-1:0] count;
  } acc_fin_t;

endpackage

FILE: hdl/ics_accum.sv
module ics_accum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  ics_pkg::in_item_t item_i,
  output ics_pkg::acc_fin_t fin_o
);

  logic [ics_pkg::SumW-1:0]   sum_q, sum_d;
  logic [ics_pkg::CountW-1:0] count_q, count_d;
  logic [ics_pkg::ByteW-1:0]  held_q, held_d;
  logic                       odd_q, odd_d;

  logic [ics_pkg::WordW-1:0]  word;
  logic                       add_word;
  logic [ics_pkg::SumW-1:0]   sum_new;
  logic [ics_pkg::CountW-1:0] count_new;
  logic [ics_pkg::SumW-1:0]   count_ext;

  always_comb begin
    if (odd_q) begin
      word = {held_q, item_i.data_byte};
    end else begin
      word = {item_i.data_byte, {ics_pkg::ByteW{1'b0}}};
    end
    add_word  = odd_q | item_i.last_byte;
    sum_new   = sum_q + (add_word ? {{(ics_pkg::SumW-ics_pkg::WordW){1'b0}}, word}
                                  : '0);
    count_new = count_q + 16'd1;
    count_ext = {{(ics_pkg::SumW-ics_pkg::CountW){1'b0}}, count_new};

    fin_o.sum   = sum_new;
    fin_o.count = count_new;
    case (item_i.proto_mode)
      ics_pkg::PROTO_UDP: begin
        fin_o.term = count_ext + (ics_pkg::PROTO_UDP_ADD - ics_pkg::ADDR_PAIR_LEN);
      end
      ics_pkg::PROTO_TCP: begin
        fin_o.term = count_ext + (ics_pkg::PROTO_TCP_ADD - ics_pkg::ADDR_PAIR_LEN);
      end
      default: begin
        fin_o.term = '0;
      end
    endcase
  end

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    held_d  = held_q;
    odd_d   = odd_q;
    if (accept_i) begin
      if (item_i.last_byte) begin
        sum_d   = '0;
        count_d = '0;
        held_d  = '0;
        odd_d   = 1'b0;
      end else begin
        sum_d   = sum_new;
        count_d = count_new;
        if (odd_q) begin
          held_d = '0;
          odd_d  = 1'b0;
        end else begin
          held_d = item_i.data_byte;
          odd_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      held_q  <= '0;
      odd_q   <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      held_q  <= held_d;
      odd_q   <= odd_d;
    end
  end

endmodule

FILE: hdl/internet_checksum_stream.sv
// Streaming ones' complement checksum over a byte message.
// The input channel takes one byte per item, first byte of each pair high;
// last_byte closes the message and proto_mode on that byte selects the
// pseudo-header addition (UDP or TCP protocol number plus the length term).
// The output channel gives one item per message: the complemented folded sum
// and the byte count, both 16 bits.
// An item is taken on a clock edge with valid high and stall low.
// A byte is taken every cycle while the output side keeps up, so throughput
// is one byte per cycle; the byte-pair accumulate is a single 32-bit add.
// The result of a message goes from the edge that takes its last byte
// through s1, which holds the totals, s2, which adds the pseudo term, and
// the output register, which folds the carries and complements.
// When the receiver stalls, the result holds in the output register and the
// two stages behind it fill; the input is stalled only once all three hold
// a result. Bytes that are not last never wait on a free result slot.
// Reset clears the running sum, the byte count and all pipeline valid flags.
module internet_checksum_stream (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ics_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ics_pkg::out_item_t out_item_o
);

  logic              accept;
  ics_pkg::acc_fin_t fin;

  logic                       s1_valid_q;
  ics_pkg::acc_fin_t          s1_q;
  logic                       s2_valid_q;
  logic [ics_pkg::SumW-1:0]   s2_sum_q;
  logic [ics_pkg::CountW-1:0] s2_count_q;
  logic                       out_valid_q;
  ics_pkg::out_item_t         out_q;

  logic adv_out, adv_s2, adv_s1;
  logic [ics_pkg::WordW:0]   fold_a;
  logic [ics_pkg::WordW-1:0] fold_b;

  assign adv_out = !out_valid_q || !out_stall_i;
  assign adv_s2  = !s2_valid_q || adv_out;
  assign adv_s1  = !s1_valid_q || adv_s2;

  assign in_stall_o = in_item_i.last_byte && !adv_s1;
  assign accept     = in_valid_i && !in_stall_o;

  ics_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .fin_o    (fin)
  );

  always_comb begin
    fold_a = {1'b0, s2_sum_q[ics_pkg::WordW-1:0]}
           + {1'b0, s2_sum_q[ics_pkg::SumW-1:ics_pkg::WordW]};
    fold_b = fold_a[ics_pkg::WordW-1:0]
           + {{(ics_pkg::WordW-1){1'b0}}, fold_a[ics_pkg::WordW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid_q <= accept && in_item_i.last_byte;
      end
      if (adv_s2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (adv_out) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1 && accept && in_item_i.last_byte) begin
      s1_q <= fin;
    end
    if (adv_s2 && s1_valid_q) begin
      s2_sum_q   <= s1_q.sum + s1_q.term;
      s2_count_q <= s1_q.count;
    end
    if (adv_out && s2_valid_q) begin
      out_q.checksum_value <= ~fold_b;
      out_q.bytes_summed   <= s2_count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: hdl/ics_checker.sv
`include "internet_checksum_stream_defines.svh"

module ics_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input ics_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ics_pkg::out_item_t out_item_o
);

  // A stalled result stays put.
  `ICS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // A taken last byte reaches the output register through s1 and s2, unless a receiver stall holds it.
  `ICS_ASSERT_NEXT(a_result_due, in_valid_i && !in_stall_o && in_item_i.last_byte, ##2 out_valid_o)

  // With the output register empty the whole pipeline can move.
  `ICS_ASSERT_NOW(a_no_idle_stall, !out_valid_o, !in_stall_o)

  // A byte that does not close a message is never held back.
  `ICS_ASSERT_NOW(a_body_flows, in_valid_i && !in_item_i.last_byte, !in_stall_o)

endmodule

bind internet_checksum_stream ics_checker u_ics_checker (.*);
